>>> src/qlwr_pkg.sv
// Shared types, constants and codes of the learned way-replacement block.
`default_nettype none

package qlwr_pkg;

  // Default geometry and fixed-point scale
  localparam int unsigned SET_COUNT_DEF   = 64;
  localparam int unsigned TAG_BUCKETS_DEF = 16;
  localparam int unsigned FIXED_SCALE_DEF = 1000;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SET_W    = 6;
  localparam int unsigned TAG_W    = 24;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LR_W     = 10;
  localparam int unsigned DISC_W   = 10;
  localparam int unsigned EXPL_W   = 7;
  localparam int unsigned REWARD_W = 21;

  // Arithmetic widths of the update path
  localparam int unsigned PROD1_W = DISC_W + VALUE_W;  // discount * |best|
  localparam int unsigned DIFF_W  = 44;                // target - old, signed
  localparam int unsigned DIV_W   = 52;                // |learning_rate * diff| < 2^52
  localparam int unsigned NV_W    = DIV_W + 2;         // old + quotient, signed

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_PERCENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_REWARD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_REWARD     = 3'd4;

  localparam logic [LR_W-1:0]            LR_RST   = 10'd100;
  localparam logic [DISC_W-1:0]          DISC_RST = 10'd900;
  localparam logic [EXPL_W-1:0]          EXPL_RST = 7'd10;
  localparam logic signed [REWARD_W-1:0] HIT_RST  = 21'sd1000;
  localparam logic signed [REWARD_W-1:0] MISS_RST = -21'sd1000;

  // Operation codes; the fourth code is a no-op
  localparam logic [OP_W-1:0] OP_CHOOSE = 2'd0;
  localparam logic [OP_W-1:0] OP_HIT    = 2'd1;
  localparam logic [OP_W-1:0] OP_MISS   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [SET_W-1:0] set_index;
    logic [TAG_W-1:0] line_tag;
    logic             way_index;
    logic [PCT_W-1:0] random_percent;
    logic             random_choice;
  } in_t;

  typedef struct packed {
    logic                      chosen_way;
    logic signed [VALUE_W-1:0] updated_value;
  } out_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;  // clear one table row
    logic load;   // capture the input transaction
    logic hash;   // tag times reciprocal
    logic addr;   // form row address
    logic read;   // read table row
    logic eval;   // choose result, or start first division
    logic tgt;    // form target - old
    logic mul2;   // start second division
    logic wb;     // write back saturated value
    logic push;   // move result into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_update;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> src/qlwr_div.sv
// Divider by a constant: reciprocal multiplication, one partial product per cycle.
`default_nettype none

module qlwr_div #(
  parameter int unsigned DIV_W   = qlwr_pkg::DIV_W,
  parameter int unsigned DIVISOR = qlwr_pkg::FIXED_SCALE_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  output logic      [DIV_W-1:0] quot_o,
  output logic                  done_o
);

  // quotient = (dividend * RECIP) >> SH, exact for every DIV_W-bit dividend
  localparam int unsigned SH    = DIV_W + $clog2(DIVISOR);
  localparam int unsigned RW    = DIV_W + 1;
  localparam int unsigned CW    = SH + 1;
  localparam logic [RW-1:0] RECIP =
      RW'(((CW'(1) << SH) + CW'(DIVISOR) - CW'(1)) / CW'(DIVISOR));
  localparam int unsigned AL    = DIV_W / 2;
  localparam int unsigned AH    = DIV_W - AL;
  localparam int unsigned BL    = RW / 2;
  localparam int unsigned BH    = RW - BL;
  localparam int unsigned PW    = AH + BH;
  localparam int unsigned ACC_W = SH + DIV_W;
  localparam int unsigned SW    = $clog2(AL + BL + 1);

  logic [DIV_W-1:0] dvd_q;
  logic [ACC_W-1:0] acc_q;
  logic [1:0]       step_q;
  logic             run_q;
  logic             done_q;
  logic [AH-1:0]    a_part;
  logic [BH-1:0]    b_part;
  logic [PW-1:0]    pp;
  logic [SW-1:0]    pp_shift;

  // step bit 0 picks the dividend half, step bit 1 the reciprocal half
  assign a_part   = step_q[0] ? dvd_q[DIV_W-1:AL] : AH'(dvd_q[AL-1:0]);
  assign b_part   = step_q[1] ? RECIP[RW-1:BL] : BH'(RECIP[BL-1:0]);
  assign pp       = PW'(a_part) * PW'(b_part);
  assign pp_shift = (step_q[0] ? SW'(AL) : SW'(0)) + (step_q[1] ? SW'(BL) : SW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      step_q <= '0;
      done_q <= 1'b0;
    end else if (run_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd3) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_q + (ACC_W'(pp) << pp_shift);
    end
  end

  assign quot_o = acc_q[SH +: DIV_W];
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> src/qlwr_dp.sv
// Datapath: config registers, Q-value table, address hashing, update arithmetic, output register.
`default_nettype none

module qlwr_dp #(
  parameter int unsigned SET_COUNT   = qlwr_pkg::SET_COUNT_DEF,
  parameter int unsigned TAG_BUCKETS = qlwr_pkg::TAG_BUCKETS_DEF,
  parameter int unsigned FIXED_SCALE = qlwr_pkg::FIXED_SCALE_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire qlwr_pkg::cmd_t                     cmd_i,
  output qlwr_pkg::sts_t                          sts_o,
  input  wire qlwr_pkg::in_t                      in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output qlwr_pkg::out_t                          out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [qlwr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [qlwr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned VW       = qlwr_pkg::VALUE_W;
  localparam int unsigned TAG_W    = qlwr_pkg::TAG_W;
  localparam int unsigned NV_W     = qlwr_pkg::NV_W;
  localparam int unsigned DIV_W    = qlwr_pkg::DIV_W;
  localparam int unsigned DIFF_W   = qlwr_pkg::DIFF_W;
  localparam int unsigned ROWS     = SET_COUNT * TAG_BUCKETS;
  localparam int unsigned ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SM_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned BKT_W    = (TAG_BUCKETS > 1) ? $clog2(TAG_BUCKETS) : 1;
  localparam int unsigned SET_N    = 2 ** qlwr_pkg::SET_W;
  // tag / TAG_BUCKETS as (tag * HASH_M) >> HASH_S, exact for 24-bit tags
  localparam int unsigned HASH_S   = TAG_W + $clog2(TAG_BUCKETS);
  localparam int unsigned HASH_M_W = TAG_W + 2;
  localparam logic [63:0] HASH_M   =
      ((64'd1 << HASH_S) + 64'(TAG_BUCKETS) - 64'd1) / 64'(TAG_BUCKETS);
  localparam int unsigned HPROD_W  = TAG_W + HASH_M_W;

  // configuration registers
  logic [qlwr_pkg::LR_W-1:0]            lr_q;
  logic [qlwr_pkg::DISC_W-1:0]          disc_q;
  logic [qlwr_pkg::EXPL_W-1:0]          expl_q;
  logic signed [qlwr_pkg::REWARD_W-1:0] hit_q;
  logic signed [qlwr_pkg::REWARD_W-1:0] miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= qlwr_pkg::LR_RST;
      disc_q <= qlwr_pkg::DISC_RST;
      expl_q <= qlwr_pkg::EXPL_RST;
      hit_q  <= qlwr_pkg::HIT_RST;
      miss_q <= qlwr_pkg::MISS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qlwr_pkg::CFG_LEARNING_RATE:   lr_q   <= cfg_data_i[qlwr_pkg::LR_W-1:0];
        qlwr_pkg::CFG_DISCOUNT:        disc_q <= cfg_data_i[qlwr_pkg::DISC_W-1:0];
        qlwr_pkg::CFG_EXPLORE_PERCENT: expl_q <= cfg_data_i[qlwr_pkg::EXPL_W-1:0];
        qlwr_pkg::CFG_HIT_REWARD:      hit_q  <= $signed(cfg_data_i);
        qlwr_pkg::CFG_MISS_REWARD:     miss_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------- address ----------------
  qlwr_pkg::in_t      item_q;
  logic [HPROD_W-1:0] hprod_q;
  logic [ROW_W-1:0]   row_q;
  logic [TAG_W-1:0]   hquot;
  logic [TAG_W-1:0]   bkt_full;
  logic [BKT_W-1:0]   bucket;
  logic [SM_W-1:0]    set_lut [SET_N];
  logic [ROW_W-1:0]   row_d;

  for (genvar g = 0; g < SET_N; g++) begin : g_set_lut
    assign set_lut[g] = SM_W'(g % SET_COUNT);
  end

  assign hquot    = TAG_W'(hprod_q >> HASH_S);
  assign bkt_full = item_q.line_tag - TAG_W'(hquot * TAG_W'(TAG_BUCKETS));
  assign bucket   = bkt_full[BKT_W-1:0];
  assign row_d    = ROW_W'(set_lut[item_q.set_index]) * ROW_W'(TAG_BUCKETS)
                  + ROW_W'(bucket);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q  <= in_data_i;
    if (cmd_i.hash) hprod_q <= HPROD_W'(item_q.line_tag) * HPROD_W'(HASH_M_W'(HASH_M));
    if (cmd_i.addr) row_q   <= row_d;
  end

  // ---------------- table: one row holds both ways ----------------
  logic [2*VW-1:0]  mem_q [ROWS];
  logic [2*VW-1:0]  rdata_q;
  logic [ROW_W-1:0] clr_row_q;
  logic             mem_we;
  logic [ROW_W-1:0] mem_waddr;
  logic [2*VW-1:0]  mem_wdata;
  logic [2*VW-1:0]  new_row;

  assign mem_we    = cmd_i.clear | cmd_i.wb;
  assign mem_waddr = cmd_i.clear ? clr_row_q : row_q;
  assign mem_wdata = cmd_i.clear ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we)     mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.read) rdata_q <= mem_q[row_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
    end else if (cmd_i.clear) begin
      clr_row_q <= sts_o.clr_last ? '0 : clr_row_q + ROW_W'(1);
    end
  end

  // ---------------- evaluation ----------------
  logic signed [VW-1:0] q0, q1, best, old;
  logic [VW-1:0]        best_mag;
  logic                 choose_way;
  logic                 is_update;
  logic [qlwr_pkg::PROD1_W-1:0] prod1;

  assign q0         = $signed(rdata_q[VW-1:0]);
  assign q1         = $signed(rdata_q[2*VW-1:VW]);
  assign best       = (q1 > q0) ? q1 : q0;
  assign old        = item_q.way_index ? q1 : q0;
  assign best_mag   = best[VW-1] ? VW'(-best) : VW'(best);
  assign prod1      = qlwr_pkg::PROD1_W'(disc_q) * qlwr_pkg::PROD1_W'(best_mag);
  assign choose_way = (item_q.random_percent < expl_q) ? item_q.random_choice : (q1 > q0);
  assign is_update  = (item_q.operation == qlwr_pkg::OP_HIT) ||
                      (item_q.operation == qlwr_pkg::OP_MISS);

  // ---------------- shared divider by FIXED_SCALE ----------------
  logic                   div_start;
  logic [DIV_W-1:0]       div_dvd;
  logic [DIV_W-1:0]       div_quot;
  logic                   div_done;
  logic                   sign_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [DIFF_W-2:0]      diff_mag;
  logic [qlwr_pkg::LR_W+DIFF_W-2:0] prod2;

  assign diff_mag  = diff_q[DIFF_W-1] ? (DIFF_W-1)'(-diff_q) : (DIFF_W-1)'(diff_q);
  assign prod2     = (qlwr_pkg::LR_W+DIFF_W-1)'(lr_q) * (qlwr_pkg::LR_W+DIFF_W-1)'(diff_mag);
  assign div_start = (cmd_i.eval && is_update) || cmd_i.mul2;
  assign div_dvd   = cmd_i.mul2 ? DIV_W'(prod2) : DIV_W'(prod1);

  qlwr_div #(
    .DIV_W   (DIV_W),
    .DIVISOR (FIXED_SCALE)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // truncation toward zero: divide magnitudes, restore sign
  logic signed [NV_W-1:0] quot_s, reward_x, old_x, diff_full, nv;
  logic                   sat_pos, sat_neg;
  logic signed [VW-1:0]   sat_val;

  assign quot_s    = sign_q ? -$signed(NV_W'(div_quot)) : $signed(NV_W'(div_quot));
  assign reward_x  = NV_W'((item_q.operation == qlwr_pkg::OP_HIT) ? hit_q : miss_q);
  assign old_x     = NV_W'(old);
  assign diff_full = reward_x + quot_s - old_x;
  assign nv        = old_x + quot_s;
  assign sat_pos   = !nv[NV_W-1] && (|nv[NV_W-2:VW-1]);
  assign sat_neg   = nv[NV_W-1] && !(&nv[NV_W-2:VW-1]);
  assign sat_val   = sat_pos ? $signed({1'b0, {(VW-1){1'b1}}}) :
                     sat_neg ? $signed({1'b1, {(VW-1){1'b0}}}) : $signed(nv[VW-1:0]);
  assign new_row   = item_q.way_index ? {sat_val, q0} : {q1, sat_val};

  qlwr_pkg::out_t res_q;
  qlwr_pkg::out_t out_q;
  logic           out_valid_q;

  always_ff @(posedge clk_i) begin
    if (div_start) sign_q <= cmd_i.mul2 ? diff_q[DIFF_W-1] : best[VW-1];
    if (cmd_i.tgt) diff_q <= DIFF_W'(diff_full);
    if (cmd_i.eval && !is_update) begin
      res_q.chosen_way    <= (item_q.operation == qlwr_pkg::OP_CHOOSE) ? choose_way : 1'b0;
      res_q.updated_value <= '0;
    end else if (cmd_i.wb) begin
      res_q.chosen_way    <= 1'b0;
      res_q.updated_value <= sat_val;
    end
    if (cmd_i.push) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.clr_last  = clr_row_q == ROW_W'(ROWS - 1);
  assign sts_o.is_update = is_update;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> src/qlwr_ctrl.sv
// Controller: sequences table clear, lookup, the two divisions and write-back.
`default_nettype none

module qlwr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire qlwr_pkg::sts_t sts_i,
  output qlwr_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_ADDR, ST_READ, ST_EVAL,
    ST_DIV1, ST_TGT, ST_MUL2, ST_DIV2, ST_WB, ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.is_update ? ST_DIV1 : ST_DONE;
      end
      ST_DIV1: begin
        if (sts_i.div_done) state_d = ST_TGT;
      end
      ST_TGT: begin
        cmd_o.tgt = 1'b1;
        state_d   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_DIV2;
      end
      ST_DIV2: begin
        if (sts_i.div_done) state_d = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // wait for room in the output register
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

`default_nettype wire

>>> src/qlearning_way_replacement.sv
// Top level of the learned two-way victim chooser.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one request per
// transaction: choose a victim way, or update one Q-value after a hit or a
// miss fill. Each request gives exactly one result on the output channel
// (out_valid_o/out_ready_i/out_data_o). Items are handled one at a time.
// Choose and no-op requests pass through the hash, address, read and
// evaluate states. Update requests: two divisions by FIXED_SCALE, each a
// reciprocal multiplication built from four partial products (one per
// cycle), set the pace.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls with a result still held, the
// following result waits inside the block and in_ready_o stays low.
// Reset clears the configuration to its defaults and then runs a clearing
// pass over the table, one row (both ways) per cycle over all
// SET_COUNT*TAG_BUCKETS rows (1024 by default); in_ready_o is low during
// the pass. Configuration writes via cfg_we_i are taken at any time.
`default_nettype none

module qlearning_way_replacement #(
  parameter int unsigned SET_COUNT   = qlwr_pkg::SET_COUNT_DEF,
  parameter int unsigned TAG_BUCKETS = qlwr_pkg::TAG_BUCKETS_DEF,
  parameter int unsigned FIXED_SCALE = qlwr_pkg::FIXED_SCALE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire qlwr_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output qlwr_pkg::out_t                       out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [qlwr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [qlwr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  qlwr_pkg::cmd_t cmd;
  qlwr_pkg::sts_t sts;

  qlwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qlwr_dp #(
    .SET_COUNT   (SET_COUNT),
    .TAG_BUCKETS (TAG_BUCKETS),
    .FIXED_SCALE (FIXED_SCALE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

>>> src/qlwr_checker.sv
// Port-level checker for the learned way chooser, bound to the top level.
`default_nettype none

module qlwr_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire qlwr_pkg::out_t out_data_o
);

  // a held result must not change before it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a result carries either a way or an updated value, never both
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.chosen_way && (out_data_o.updated_value != 0)))
    else $error("result carries way and value together");

  // the input stays closed through hash, address, read and evaluate after a transaction is taken
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o
                                 ##1 !in_ready_o)
    else $error("input taken during lookup");

endmodule

bind qlearning_way_replacement qlwr_checker u_qlwr_checker (.*);

`default_nettype wire
